// File: hdl/anisotropic_diffusion_pass_defines.svh
// ----------------------------------------------------------------------------
// Anisotropic diffusion pass: assertion macros
// Shared concurrent assertion forms, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ANISOTROPIC_DIFFUSION_PASS_DEFINES_SVH
`define ANISOTROPIC_DIFFUSION_PASS_DEFINES_SVH

// same-cycle implication
`define ADP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("adp: same-cycle check failed");

// next-cycle implication
`define ADP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("adp: next-cycle check failed");

`endif

// File: hdl/adp_pkg.sv
// ----------------------------------------------------------------------------
// Anisotropic diffusion pass: package
// Widths, register indexes, command/status types and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package adp_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WID_W     = 11;
    localparam int HGT_W     = 16;
    localparam int K_W       = 8;
    localparam int PIX_W     = 8;
    localparam int K2_W      = 2 * K_W;
    localparam int DEN_W     = K2_W + 1;
    localparam int PROD_W    = PIX_W + K2_W;
    localparam int FRAC_BITS = 16;
    localparam int Q_W       = PIX_W + FRAC_BITS;
    localparam int ACC_W     = Q_W + 3;
    localparam int WHOLE_W   = ACC_W - 1 - FRAC_BITS;
    localparam int RECIP_W   = 12;
    localparam int RECIP_SH  = 15;
    localparam int RPROD_W   = WHOLE_W + RECIP_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // 1/12 ~ 2731 / 2^15, exact after truncation for 10-bit magnitudes
    localparam logic [RECIP_W-1:0] RECIP12 = 12'd2731;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_K      = 2'd2;

    localparam logic [WID_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [HGT_W-1:0] HEIGHT_RST = 16'd480;
    localparam logic [K_W-1:0]   K_RST      = 8'd24;
    localparam logic [PIX_W-1:0] PIX_MAX    = 8'd255;

    typedef enum logic [1:0] {
        RA_FIRST,
        RA_WEST,
        RA_EAST
    } rd_sel_t;

    typedef enum logic [1:0] {
        CAP_NONE,
        CAP_FIRST,
        CAP_WEST,
        CAP_EAST
    } cap_sel_t;

    typedef struct packed {
        logic     load;
        rd_sel_t  rd_sel;
        cap_sel_t cap;
        logic     mul;
        logic     div_start;
        logic     acc_add;
        logic     fin1;
        logic     fin2;
        logic     out_load;
        logic     commit;
    } adp_cmd_t;

    typedef struct packed {
        logic emit;
        logic inner;
        logic div_busy;
        logic out_free;
        logic last_term;
    } adp_sts_t;

    // x mod 3 by folding base-4 digits (4 = 1 mod 3)
    function automatic logic [1:0] mod3(input logic [HGT_W-1:0] x);
        logic [4:0] s1;
        logic [2:0] s2;
        s1 = '0;
        for (int i = 0; i < HGT_W / 2; i++) begin
            s1 = s1 + 5'(x[2*i +: 2]);
        end
        s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
        if (s2 >= 3'd6) begin
            s2 = s2 - 3'd6;
        end else if (s2 >= 3'd3) begin
            s2 = s2 - 3'd3;
        end
        return s2[1:0];
    endfunction

endpackage

`default_nettype wire

// File: hdl/adp_div.sv
// ----------------------------------------------------------------------------
// Anisotropic diffusion pass: flow-term divider
// Restoring divider, one quotient bit per cycle: (num * 2^16) / den.
// ----------------------------------------------------------------------------
`default_nettype none

module adp_div
    import adp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [PROD_W-1:0] num,
    input  wire logic [DEN_W-1:0]  den,
    output logic                   busy,
    output logic [Q_W-1:0]         quo
);

    localparam int LOW_BITS = Q_W - FRAC_BITS;
    localparam int CNT_W    = $clog2(Q_W);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [Q_W-1:0]   dvd_reg;
    logic [Q_W-1:0]   quo_reg;
    logic [DEN_W:0]   rem_sh;
    logic             ge;

    // quotient fits Q_W bits since num < 2^8 * den
    assign rem_sh = {rem_reg, dvd_reg[Q_W-1]};
    assign ge     = (rem_sh >= {1'b0, den});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(Q_W - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= DEN_W'(num[PROD_W-1:LOW_BITS]);
            dvd_reg <= {num[LOW_BITS-1:0], FRAC_BITS'(0)};
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? DEN_W'(rem_sh - {1'b0, den}) : DEN_W'(rem_sh);
            dvd_reg <= {dvd_reg[Q_W-2:0], 1'b0};
            quo_reg <= {quo_reg[Q_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

// File: hdl/adp_ctrl.sv
// ----------------------------------------------------------------------------
// Anisotropic diffusion pass: controller
// Sequences reads, the four flow terms, result and commit for one word.
// ----------------------------------------------------------------------------
`default_nettype none
`include "anisotropic_diffusion_pass_defines.svh"

module adp_ctrl
    import adp_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire adp_sts_t sts,
    output adp_cmd_t      cmd
);

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_RD_A = 12'b000000000010,
        S_RD_B = 12'b000000000100,
        S_RD_C = 12'b000000001000,
        S_RD_D = 12'b000000010000,
        S_MUL  = 12'b000000100000,
        S_DST  = 12'b000001000000,
        S_DIV  = 12'b000010000000,
        S_ACC  = 12'b000100000000,
        S_FIN1 = 12'b001000000000,
        S_FIN2 = 12'b010000000000,
        S_OUT  = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RA_FIRST;
        cmd.cap    = CAP_NONE;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_RD_A;
                end
            end
            S_RD_A: begin
                cmd.rd_sel = RA_FIRST;
                state_next = S_RD_B;
            end
            S_RD_B: begin
                cmd.cap    = CAP_FIRST;
                cmd.rd_sel = RA_WEST;
                state_next = S_RD_C;
            end
            S_RD_C: begin
                cmd.cap    = CAP_WEST;
                cmd.rd_sel = RA_EAST;
                state_next = S_RD_D;
            end
            S_RD_D: begin
                cmd.cap    = CAP_EAST;
                state_next = sts.inner ? S_MUL : S_FIN2;
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_DST;
            end
            S_DST: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV: begin
                if (!sts.div_busy) begin
                    state_next = S_ACC;
                end
            end
            S_ACC: begin
                cmd.acc_add = 1'b1;
                state_next  = sts.last_term ? S_FIN1 : S_MUL;
            end
            S_FIN1: begin
                cmd.fin1   = 1'b1;
                state_next = S_FIN2;
            end
            S_FIN2: begin
                cmd.fin2   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!sts.emit) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end else if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.commit   = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    `ADP_ASSERT_NEXT(a_accept_reads, s_tvalid && s_tready, state_reg == S_RD_A)
    `ADP_ASSERT_IMP(a_div_idle_start, cmd.div_start, !sts.div_busy)
    `ADP_ASSERT_IMP(a_emit_with_commit, cmd.commit && sts.emit, cmd.out_load)

endmodule

`default_nettype wire

// File: hdl/adp_datapath.sv
// ----------------------------------------------------------------------------
// Anisotropic diffusion pass: datapath
// Config registers, row stores, counters, flow terms, result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "anisotropic_diffusion_pass_defines.svh"

module adp_datapath
    import adp_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_wdata,
    input  wire logic [PIX_W-1:0]     s_tdata,
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [PIX_W-1:0]          m_tdata,
    output logic                      m_tlast,
    input  wire adp_cmd_t             cmd,
    output adp_sts_t                  sts
);

    // configuration
    logic [WID_W-1:0] width_reg;
    logic [HGT_W-1:0] height_reg;
    logic [K_W-1:0]   k_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            k_reg      <= K_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_wdata[WID_W-1:0];
                REG_HEIGHT: height_reg <= cfg_wdata[HGT_W-1:0];
                REG_K:      k_reg      <= cfg_wdata[K_W-1:0];
                default: ;
            endcase
        end
    end

    logic [WID_W-1:0] w_eff;
    logic [HGT_W-1:0] h_eff;

    always_comb begin
        if (width_reg < WID_W'(3)) begin
            w_eff = WID_W'(3);
        end else if (width_reg > WID_W'(MAX_WIDTH)) begin
            w_eff = WID_W'(MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        h_eff = (height_reg < HGT_W'(3)) ? HGT_W'(3) : height_reg;
    end

    // position state
    logic [COL_W-1:0] col_reg, col_next;
    logic [HGT_W-1:0] row_reg, row_next;
    logic [WID_W-1:0] pend_reg, pend_next;

    logic [COL_W-1:0] c_now;
    logic [HGT_W-1:0] r_now;
    logic [WID_W-1:0] pe_now;
    logic [1:0]       rm_now;

    always_comb begin
        c_now  = ({1'b0, col_reg} < w_eff) ? col_reg : COL_W'(w_eff - 1'b1);
        r_now  = (row_reg < h_eff) ? row_reg : (h_eff - 1'b1);
        pe_now = (pend_reg > w_eff) ? w_eff : pend_reg;
        rm_now = mod3(r_now);
    end

    // per-word latched context
    logic             act_reg;
    logic [PIX_W-1:0] px_reg;
    logic [COL_W-1:0] c_reg;
    logic [HGT_W-1:0] r_reg;
    logic [COL_W-1:0] p_reg;
    logic [WID_W-1:0] pe_reg;
    logic             pend_rd_reg;
    logic             emit_reg;
    logic             inner_reg;
    logic             flast_reg;
    logic [1:0]       wsel_reg, midsel_reg, topsel_reg, bsel_reg;
    logic [K2_W-1:0]  k2_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg     <= s_tuser;
            px_reg      <= s_tdata;
            c_reg       <= c_now;
            r_reg       <= r_now;
            p_reg       <= COL_W'(w_eff - pe_now);
            pe_reg      <= pe_now;
            pend_rd_reg <= s_tuser || (r_now == '0);
            emit_reg    <= (s_tuser || (r_now == '0)) ? (pe_now != '0) : 1'b1;
            inner_reg   <= !s_tuser && (r_now != '0) && (r_now != HGT_W'(1))
                           && (c_now != '0) && (c_now != COL_W'(w_eff - 1'b1));
            flast_reg   <= (pe_now == WID_W'(1));
            wsel_reg    <= rm_now;
            midsel_reg  <= (rm_now == 2'd0) ? 2'd2 : rm_now - 2'd1;
            topsel_reg  <= (rm_now == 2'd2) ? 2'd0 : rm_now + 2'd1;
            bsel_reg    <= mod3(h_eff - 1'b1);
            k2_reg      <= K2_W'(k_reg) * K2_W'(k_reg);
        end
    end

    // row stores
    logic [COL_W-1:0] rd_addr;
    logic [PIX_W-1:0] rd_q [3];

    always_comb begin
        case (cmd.rd_sel)
            RA_FIRST: rd_addr = pend_rd_reg ? p_reg : c_reg;
            RA_WEST:  rd_addr = c_reg - 1'b1;
            RA_EAST:  rd_addr = c_reg + 1'b1;
            default:  rd_addr = c_reg;
        endcase
    end

    for (genvar g = 0; g < 3; g++) begin : g_store
        logic [PIX_W-1:0] mem [MAX_WIDTH];
        logic [PIX_W-1:0] q_reg;
        logic             we;

        assign we = cmd.commit && !act_reg && (wsel_reg == 2'(g));

        always_ff @(posedge aclk) begin
            if (we) begin
                mem[c_reg] <= px_reg;
            end
            q_reg <= mem[rd_addr];
        end

        assign rd_q[g] = q_reg;
    end

    logic [PIX_W-1:0] v_reg, n_reg, bot_reg, west_reg, east_reg;

    always_ff @(posedge aclk) begin
        case (cmd.cap)
            CAP_FIRST: begin
                v_reg   <= rd_q[midsel_reg];
                n_reg   <= rd_q[topsel_reg];
                bot_reg <= rd_q[bsel_reg];
            end
            CAP_WEST: west_reg <= rd_q[midsel_reg];
            CAP_EAST: east_reg <= rd_q[midsel_reg];
            default: ;
        endcase
    end

    // flow terms: d*K^2*2^16 / (K^2 + d^2), one at a time
    logic [1:0]        term_reg;
    logic [PIX_W-1:0]  nb;
    logic [PIX_W:0]    dif;
    logic [PIX_W-1:0]  dmag;
    logic              dneg_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [DEN_W-1:0]  den_reg;
    logic              div_busy;
    logic [Q_W-1:0]    quo;
    logic [ACC_W-1:0]  acc_reg;
    logic [Q_W-1:0]    term_val;

    always_comb begin
        case (term_reg)
            2'd0:    nb = n_reg;
            2'd1:    nb = px_reg;
            2'd2:    nb = west_reg;
            default: nb = east_reg;
        endcase
        dif  = {1'b0, nb} - {1'b0, v_reg};
        dmag = dif[PIX_W] ? PIX_W'(-dif) : dif[PIX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            dneg_reg <= dif[PIX_W];
            prod_reg <= PROD_W'(dmag) * PROD_W'(k2_reg);
            den_reg  <= {1'b0, k2_reg} + {1'b0, K2_W'(dmag) * K2_W'(dmag)};
        end
    end

    adp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (prod_reg),
        .den     (den_reg),
        .busy    (div_busy),
        .quo     (quo)
    );

    // zero denominator only with K = 0 and d = 0: term counts as zero
    assign term_val = (den_reg == '0) ? '0 : quo;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            term_reg <= '0;
            acc_reg  <= '0;
        end else if (cmd.acc_add) begin
            term_reg <= term_reg + 1'b1;
            acc_reg  <= dneg_reg ? acc_reg - ACC_W'(term_val)
                                 : acc_reg + ACC_W'(term_val);
        end
    end

    // sum / 2^16 / 12, both toward zero, then add and clamp
    logic [ACC_W-1:0]   amag;
    logic               sneg_reg;
    logic [RPROD_W-1:0] rprod_reg;
    logic [PIX_W+2:0]   rsum;
    logic [PIX_W-1:0]   clamp_val;
    logic [PIX_W-1:0]   res_reg;

    assign amag = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : acc_reg;

    always_ff @(posedge aclk) begin
        if (cmd.fin1) begin
            sneg_reg  <= acc_reg[ACC_W-1];
            rprod_reg <= RPROD_W'(amag[ACC_W-2:FRAC_BITS]) * RPROD_W'(RECIP12);
        end
    end

    always_comb begin
        rsum = sneg_reg
             ? {3'b0, v_reg} - (PIX_W+3)'(rprod_reg[RPROD_W-1:RECIP_SH])
             : {3'b0, v_reg} + (PIX_W+3)'(rprod_reg[RPROD_W-1:RECIP_SH]);
        if (rsum[PIX_W+2]) begin
            clamp_val = '0;
        end else if (rsum[PIX_W+1:PIX_W] != 2'b00) begin
            clamp_val = PIX_MAX;
        end else begin
            clamp_val = rsum[PIX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fin2) begin
            res_reg <= inner_reg ? clamp_val : (pend_rd_reg ? bot_reg : v_reg);
        end
    end

    // output register
    logic             m_valid_reg;
    logic [PIX_W-1:0] m_data_reg;
    logic             m_last_reg;
    logic             out_free;

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg <= res_reg;
            m_last_reg <= pend_rd_reg && flast_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // counters
    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        pend_next = pend_reg;
        if (pend_rd_reg) begin
            pend_next = pe_reg - WID_W'(emit_reg);
        end
        if (!act_reg) begin
            if ({1'b0, c_reg} + 1'b1 >= w_eff) begin
                col_next = '0;
                if ({1'b0, r_reg} + 1'b1 >= {1'b0, h_eff}) begin
                    row_next  = '0;
                    pend_next = w_eff;
                end else begin
                    row_next = r_reg + 1'b1;
                end
            end else begin
                col_next = c_reg + 1'b1;
                row_next = r_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            pend_reg <= '0;
        end else if (cmd.commit) begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            pend_reg <= pend_next;
        end
    end

    assign sts.emit      = emit_reg;
    assign sts.inner     = inner_reg;
    assign sts.div_busy  = div_busy;
    assign sts.out_free  = out_free;
    assign sts.last_term = (term_reg == 2'd3);

    `ADP_ASSERT_IMP(a_out_load_free, cmd.out_load, out_free)
    `ADP_ASSERT_IMP(a_pend_bound, 1'b1, pend_reg <= WID_W'(MAX_WIDTH))
    `ADP_ASSERT_NEXT(a_div_runs, cmd.div_start, div_busy)

endmodule

`default_nettype wire

// File: hdl/anisotropic_diffusion_pass.sv
// Sequence: a border, top-row or flush word goes from the reads straight to the result,
//   while an inner pixel first runs its four flow terms one by one through one divider.
// Flow: one word at a time; the next word is taken the cycle after commit, and a word
//   waits in the output state while the output register is full and m_tready is low.
// Reset: aresetn low at a clock edge clears counters, pending bottom row, output valid
//   and restores width 640, height 480, K 24; row stores are not cleared.
// ----------------------------------------------------------------------------
// Anisotropic diffusion pass: top level
// One Perona-Malik step over a raster grey stream, output one row behind.
// ----------------------------------------------------------------------------
`default_nettype none

module anisotropic_diffusion_pass
    import adp_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // register write port: 0 width, 1 height, 2 K
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_wdata,
    // source words
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [PIX_W-1:0]     s_tdata,  // [7:0] pixel_in
    input  wire logic                 s_tuser,  // [0] action: 1 = flush tick
    // filtered words
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [PIX_W-1:0]          m_tdata,  // [7:0] pixel_out
    output logic                      m_tlast   // frame_last
);

    adp_cmd_t cmd;
    adp_sts_t sts;

    // controller: one-hot sequencer over reads, terms, result, commit
    adp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: three row stores rotate by row mod 3; the divider computes
    // each flow term bit by bit; the output register frees the input side
    adp_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// Anisotropic diffusion pass: testbench
// Streams whole frames of grey pixels and flush ticks through the filter.
// An in-bench diffusion predictor works out each filtered word, and every
// output word is compared field by field. Both stream sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import adp_pkg::*;

    localparam int SETTLE     = 150;    // cycles covering an inner-pixel latency
    localparam int WDOG_LIMIT = 20000;  // cycles with no word moving on either side
    localparam int ITEM_GOAL  = 1950;
    localparam int HOLD_LEN   = 400;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [PIX_W-1:0]     s_tdata;   // [7:0] pixel_in
    logic                 s_tuser;   // [0] action
    logic                 m_tvalid;
    logic                 m_tready;
    logic [PIX_W-1:0]     m_tdata;   // [7:0] pixel_out
    logic                 m_tlast;   // frame_last

    // ------------------------------------------------------------------------
    // Diffusion predictor and queue of expected filtered words
    // ------------------------------------------------------------------------
    class diffusion_scoreboard;
        logic [PIX_W-1:0] rows [3][MAX_WIDTH];  // row stores, by row mod 3
        int unsigned      img_w, img_h, k_val;
        int unsigned      col, row, bottom_left;
        logic [PIX_W-1:0] want_pix [$];
        logic             want_last [$];
        int               errors;

        function new();
            img_w = WIDTH_RST;
            img_h = HEIGHT_RST;
            k_val = K_RST;
            col = 0;
            row = 0;
            bottom_left = 0;
            errors = 0;
            foreach (rows[i, j]) rows[i][j] = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
            case (idx)
                REG_WIDTH:  img_w = val[WID_W-1:0];
                REG_HEIGHT: img_h = val[HGT_W-1:0];
                REG_K:      k_val = val[K_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned cur_w();
            if (img_w < 3) return 3;
            if (img_w > MAX_WIDTH) return MAX_WIDTH;
            return img_w;
        endfunction

        function int unsigned cur_h();
            return (img_h < 3) ? 3 : img_h;
        endfunction

        // Q16 flow term, truncated toward zero; zero denominator gives zero
        function longint flow(int d, longint k2);
            longint den;
            den = k2 + longint'(d) * d;
            if (den == 0) return 0;
            return (longint'(d) * k2 * 65536) / den;
        endfunction

        function logic [PIX_W-1:0] smooth(int c, int n, int s, int w, int e);
            longint k2, total, res;
            k2 = longint'(k_val) * k_val;
            total = flow(n - c, k2) + flow(s - c, k2) + flow(w - c, k2) + flow(e - c, k2);
            res = c + (total / 65536) / 12;
            if (res < 0) res = 0;
            if (res > 255) res = 255;
            return res[PIX_W-1:0];
        endfunction

        // next bottom-row word of the previous frame, if any is left
        function void pop_bottom(int unsigned w, int unsigned h);
            if (bottom_left > w) bottom_left = w;
            if (bottom_left == 0) return;
            want_pix.push_back(rows[(h - 1) % 3][w - bottom_left]);
            want_last.push_back(bottom_left == 1);
            bottom_left--;
        endfunction

        function void note_input(logic act, logic [PIX_W-1:0] px);
            int unsigned w, h, c, r;
            logic [PIX_W-1:0] v;
            w = cur_w();
            h = cur_h();
            if (act == ACT_FLUSH) begin
                pop_bottom(w, h);
                return;
            end
            c = (col < w) ? col : w - 1;
            r = (row < h) ? row : h - 1;
            if (r == 0) begin
                pop_bottom(w, h);
            end else begin
                v = rows[(r + 2) % 3][c];
                if (r == 1 || c == 0 || c == w - 1)
                    want_pix.push_back(v);
                else
                    want_pix.push_back(smooth(v, rows[(r + 1) % 3][c], px,
                                              rows[(r + 2) % 3][c - 1],
                                              rows[(r + 2) % 3][c + 1]));
                want_last.push_back(1'b0);
            end
            rows[r % 3][c] = px;
            if (c + 1 >= w) begin
                col = 0;
                if (r + 1 >= h) begin
                    row = 0;
                    bottom_left = w;
                end else begin
                    row = r + 1;
                end
            end else begin
                col = c + 1;
                row = r;
            end
        endfunction

        task report_mismatch(string what);
            $display("ERROR %s", what);
            errors++;
        endtask

        task check_output(logic [PIX_W-1:0] px, logic last);
            logic [PIX_W-1:0] ep;
            logic             el;
            if (want_pix.size() == 0) begin
                report_mismatch($sformatf("unexpected word pixel=%0d last=%0b", px, last));
                return;
            end
            ep = want_pix.pop_front();
            el = want_last.pop_front();
            if (px !== ep)
                report_mismatch($sformatf("pixel_out %0d, want %0d", px, ep));
            if (last !== el)
                report_mismatch($sformatf("frame_last %0b, want %0b", last, el));
        endtask

        function int waiting();
            return want_pix.size();
        endfunction
    endclass

    diffusion_scoreboard sb;
    int  sent;          // words accepted so far
    bit  no_idle;       // when set, neither side inserts gaps
    bit  hold_rx;       // request for one long receiver stall
    int  quiet_cycles;

    anisotropic_diffusion_pass DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Monitors: sample handshakes at the edge, before any driver update lands
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            sb.note_input(s_tuser, s_tdata);
            sent++;
        end
        if (aresetn && m_tvalid && m_tready)
            sb.check_output(m_tdata, m_tlast);
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("anisotropic_diffusion_pass: mismatch");
            $finish;
        end
    end

    // receiver: random stalls, one long hold on request
    initial begin
        int gap;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_rx) begin
                m_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge aclk);
                hold_rx = 0;
            end
            gap = no_idle ? 0 : $urandom_range(0, 17);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // one source word; s_tvalid stays high straight into the next word when
    // no gap is drawn
    task send_word(logic act, logic [PIX_W-1:0] px);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
    endtask

    // all results in, then enough extra cycles for a word with no result
    task drain();
        s_tvalid <= 1'b0;
        while (sb.waiting() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    // pixel source with a few textures: noise, gentle ramps, hard extremes
    function logic [PIX_W-1:0] pick_pixel(int style, logic [PIX_W-1:0] prev);
        int step;
        case (style)
            0: return $urandom_range(0, 255);
            1: begin
                step = int'(prev) + $urandom_range(0, 40) - 20;
                if (step < 0) step = 0;
                if (step > 255) step = 255;
                return step[PIX_W-1:0];
            end
            default: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
        endcase
    endfunction

    // whole frames, optional flush noise, then flush out the bottom row
    task run_frames(int unsigned frames, int unsigned w, int unsigned h, bit noise);
        logic [PIX_W-1:0] px;
        int style;
        px = 8'd128;
        style = $urandom_range(0, 2);
        repeat (frames * w * h) begin
            if (noise && $urandom_range(0, 15) == 0)
                send_word(ACT_FLUSH, $urandom_range(0, 255));
            px = pick_pixel(style, px);
            send_word(ACT_PIXEL, px);
        end
        repeat (w + 1) send_word(ACT_FLUSH, $urandom_range(0, 255));
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int unsigned w, h, phase;
        sb = new();
        sent = 0;
        no_idle = 0;
        hold_rx = 0;
        quiet_cycles = 0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_WIDTH;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = ACT_PIXEL;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: flush on an empty block, smallest image, strongest K
        send_word(ACT_FLUSH, 8'hFF);
        drain();
        write_reg(REG_HEIGHT, 16'hFFFF);
        write_reg(REG_WIDTH, 16'd3);
        write_reg(REG_HEIGHT, 16'd3);
        write_reg(REG_K, 16'd255);
        send_word(ACT_PIXEL, 8'd0);   send_word(ACT_PIXEL, 8'd255); send_word(ACT_PIXEL, 8'd0);
        send_word(ACT_PIXEL, 8'd255); send_word(ACT_PIXEL, 8'd0);   send_word(ACT_PIXEL, 8'd255);
        send_word(ACT_PIXEL, 8'd0);   send_word(ACT_PIXEL, 8'd255); send_word(ACT_PIXEL, 8'd0);
        // bottom row drains partly through the next frame's first row
        send_word(ACT_FLUSH, 8'h00);
        send_word(ACT_PIXEL, 8'd255); send_word(ACT_PIXEL, 8'd255);
        send_word(ACT_PIXEL, 8'd255); send_word(ACT_PIXEL, 8'd0);
        send_word(ACT_PIXEL, 8'd255); send_word(ACT_PIXEL, 8'd128);
        send_word(ACT_PIXEL, 8'd1);   send_word(ACT_PIXEL, 8'd254); send_word(ACT_PIXEL, 8'd7);
        repeat (4) send_word(ACT_FLUSH, 8'hAA);
        drain();

        // K of zero, and too-small width/height registers clamp to 3
        write_reg(REG_K, 16'd0);
        write_reg(REG_WIDTH, 16'd0);
        write_reg(REG_HEIGHT, 16'd2);
        run_frames(1, 3, 3, 0);
        drain();

        // widest first row through an oversized width register, weakest K;
        // the width then drops to 3 between rows to finish the frame
        write_reg(REG_WIDTH, 16'h07FF);
        write_reg(REG_HEIGHT, 16'd0);
        write_reg(REG_K, 16'd1);
        no_idle = 1;
        repeat (MAX_WIDTH) send_word(ACT_PIXEL, pick_pixel(0, 8'd0));
        drain();
        write_reg(REG_WIDTH, 16'd3);
        repeat (6) send_word(ACT_PIXEL, pick_pixel(0, 8'd0));
        repeat (4) send_word(ACT_FLUSH, 8'h00);
        drain();

        // random phases of small images
        phase = 0;
        while (sent < ITEM_GOAL) begin
            w = ($urandom_range(0, 4) == 0) ? 3 : $urandom_range(3, 14);
            h = ($urandom_range(0, 4) == 0) ? 3 : $urandom_range(3, 6);
            write_reg(REG_WIDTH, CFG_DAT_W'(w));
            write_reg(REG_HEIGHT, CFG_DAT_W'(h));
            case ($urandom_range(0, 5))
                0:       write_reg(REG_K, 16'd255);
                1:       write_reg(REG_K, 16'd1);
                default: write_reg(REG_K, CFG_DAT_W'($urandom_range(1, 80)));
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            if (phase == 0) hold_rx = 1;
            run_frames($urandom_range(1, 3), w, h, 1);
            drain();
            phase++;
        end

        // quiet tail is covered by drain; limit comes from the watchdog
        if (sb.waiting() != 0)
            sb.report_mismatch($sformatf("%0d words never arrived", sb.waiting()));
        if (sb.errors == 0) begin
            $display("anisotropic_diffusion_pass: match");
        end else begin
            $display("anisotropic_diffusion_pass: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
+incdir+hdl
hdl/adp_pkg.sv
hdl/adp_div.sv
hdl/adp_ctrl.sv
hdl/adp_datapath.sv
hdl/anisotropic_diffusion_pass.sv
sim/tb_top.sv
